// ===== sv/ssg_pkg.sv =====
// ----------------------------------------------------------------------------
// ssg_pkg
// Shared types, register indexes and the xorshift step of the shuffled
// schedule generator.
// ----------------------------------------------------------------------------
package ssg_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int RNG_W      = 32;
    localparam int CELL_OUT_W = 8;
    localparam int POS_OUT_W  = 9;
    localparam int LEN_REG_W  = 10;
    localparam int CELL_REG_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_SEED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS  = 2'd2;

    localparam logic [RNG_W-1:0]      RESET_SEED   = 32'd1;
    localparam logic [LEN_REG_W-1:0]  RESET_LENGTH = 10'd320;
    localparam logic [CELL_REG_W-1:0] RESET_CELLS  = 9'd40;

    localparam int XS_SHIFT_A = 13;
    localparam int XS_SHIFT_B = 17;
    localparam int XS_SHIFT_C = 5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_SH_RNG,
        ST_SH_DIV,
        ST_SH_RDJ,
        ST_SH_WRI,
        ST_SH_WRJ,
        ST_READ,
        ST_OUT
    } t_state;

    function automatic logic [RNG_W-1:0] xorshift_step(input logic [RNG_W-1:0] x);
        logic [RNG_W-1:0] a;
        logic [RNG_W-1:0] b;
        a = x ^ (x << XS_SHIFT_A);
        b = a ^ (a >> XS_SHIFT_B);
        return b ^ (b << XS_SHIFT_C);
    endfunction

endpackage

// ===== sv/shuffled_schedule_generator_core.sv =====
// ----------------------------------------------------------------------------
// shuffled_schedule_generator_core
// Randomized schedule source: fills a store with slot modulo cell count,
// Fisher-Yates shuffles it with a xorshift32 generator, then serves entries.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. When a pass has to
// be built (after reset, after the last entry, after a write to the seed,
// length or cells register, or on restart) the block first fills n slots, one
// per cycle, then shuffles n-1 slots: a generator step with the read of slot
// i, the remainder steps, one per bit of the generator word, and a wait for
// the done pulse of the remainder unit, then the read of slot j and the two
// writes of the swap. Serving an entry goes through the read and output
// states. The result appears for one cycle with o_valid and cannot be held.
// ----------------------------------------------------------------------------
module shuffled_schedule_generator_core #(
    parameter int MAX_SLOTS = 512,
    parameter int MAX_CELLS = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_restart,
    input  logic                                i_cfg_we,
    input  logic [ssg_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ssg_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                o_valid,
    output logic [ssg_pkg::CELL_OUT_W-1:0]      o_cell_index,
    output logic [ssg_pkg::POS_OUT_W-1:0]       o_slot_position,
    output logic                                o_pass_end
);

    localparam int AW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int LW  = $clog2(MAX_SLOTS + 1);
    localparam int DW  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CLW = $clog2(MAX_CELLS + 1);

    ssg_pkg::t_state r_state;
    ssg_pkg::t_state n_state;

    logic [ssg_pkg::RNG_W-1:0]      r_rng;
    logic [ssg_pkg::LEN_REG_W-1:0]  r_list_length;
    logic [ssg_pkg::CELL_REG_W-1:0] r_num_cells;
    logic                           r_pass_valid;
    logic [AW-1:0]                  r_rd_pos;
    logic [AW-1:0]                  r_pos;
    logic                           r_last;
    logic [LW-1:0]                  r_i;
    logic [DW-1:0]                  r_cell;
    logic [AW-1:0]                  r_j;
    logic [DW-1:0]                  r_val_i;

    logic [LW-1:0]             eff_len;
    logic [CLW-1:0]            eff_cells;
    logic [AW-1:0]             pos_eff;
    logic                      pos_last;
    logic [ssg_pkg::RNG_W-1:0] rng_next;
    logic                      accept;
    logic                      rebuild;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [DW-1:0] mem_rdata;

    logic          div_start;
    logic          div_done;
    logic [LW-1:0] div_rem;

    always_comb begin
        if (32'(r_list_length) < 32'd2) begin
            eff_len = LW'(2);
        end else if (32'(r_list_length) > 32'(MAX_SLOTS)) begin
            eff_len = LW'(MAX_SLOTS);
        end else begin
            eff_len = LW'(r_list_length);
        end
        if (r_num_cells == '0) begin
            eff_cells = CLW'(1);
        end else if (32'(r_num_cells) > 32'(MAX_CELLS)) begin
            eff_cells = CLW'(MAX_CELLS);
        end else begin
            eff_cells = CLW'(r_num_cells);
        end
        if (LW'(r_rd_pos) >= eff_len) begin
            pos_eff = AW'(eff_len - LW'(1));
        end else begin
            pos_eff = r_rd_pos;
        end
        pos_last = (LW'(pos_eff) == eff_len - LW'(1));
    end

    assign rng_next = ssg_pkg::xorshift_step(r_rng);
    assign busy     = (r_state != ssg_pkg::ST_IDLE);
    assign accept   = start && !busy;
    assign rebuild  = i_restart || !r_pass_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ssg_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = rebuild ? ssg_pkg::ST_FILL : ssg_pkg::ST_READ;
                end
            end
            ssg_pkg::ST_FILL: begin
                if (r_i == eff_len - LW'(1)) begin
                    n_state = ssg_pkg::ST_SH_RNG;
                end
            end
            ssg_pkg::ST_SH_RNG: n_state = ssg_pkg::ST_SH_DIV;
            ssg_pkg::ST_SH_DIV: begin
                if (div_done) begin
                    n_state = ssg_pkg::ST_SH_RDJ;
                end
            end
            ssg_pkg::ST_SH_RDJ: n_state = ssg_pkg::ST_SH_WRI;
            ssg_pkg::ST_SH_WRI: n_state = ssg_pkg::ST_SH_WRJ;
            ssg_pkg::ST_SH_WRJ: begin
                n_state = (r_i == LW'(1)) ? ssg_pkg::ST_READ : ssg_pkg::ST_SH_RNG;
            end
            ssg_pkg::ST_READ: n_state = ssg_pkg::ST_OUT;
            ssg_pkg::ST_OUT:  n_state = ssg_pkg::ST_IDLE;
            default:          n_state = ssg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_i[AW-1:0];
        mem_wdata = r_cell;
        mem_re    = 1'b0;
        mem_raddr = r_i[AW-1:0];
        div_start = 1'b0;
        case (r_state)
            ssg_pkg::ST_FILL: begin
                mem_we = 1'b1;
            end
            ssg_pkg::ST_SH_RNG: begin
                mem_re    = 1'b1;
                div_start = 1'b1;
            end
            ssg_pkg::ST_SH_RDJ: begin
                mem_re    = 1'b1;
                mem_raddr = div_rem[AW-1:0];
            end
            ssg_pkg::ST_SH_WRI: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
            end
            ssg_pkg::ST_SH_WRJ: begin
                mem_we    = 1'b1;
                mem_waddr = r_j;
                mem_wdata = r_val_i;
            end
            ssg_pkg::ST_READ: begin
                mem_re    = 1'b1;
                mem_raddr = pos_eff;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ssg_pkg::ST_IDLE;
            r_rng         <= ssg_pkg::RESET_SEED | ssg_pkg::RNG_W'(1);
            r_list_length <= ssg_pkg::RESET_LENGTH;
            r_num_cells   <= ssg_pkg::RESET_CELLS;
            r_pass_valid  <= 1'b0;
            r_rd_pos      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ssg_pkg::REG_SEED: begin
                        r_rng        <= i_cfg_data | ssg_pkg::RNG_W'(1);
                        r_pass_valid <= 1'b0;
                    end
                    ssg_pkg::REG_LENGTH: begin
                        r_list_length <= i_cfg_data[ssg_pkg::LEN_REG_W-1:0];
                        r_pass_valid  <= 1'b0;
                    end
                    ssg_pkg::REG_CELLS: begin
                        r_num_cells  <= i_cfg_data[ssg_pkg::CELL_REG_W-1:0];
                        r_pass_valid <= 1'b0;
                    end
                    default: begin
                        r_pass_valid <= r_pass_valid;
                    end
                endcase
            end
            if (r_state == ssg_pkg::ST_SH_RNG) begin
                r_rng <= rng_next;
            end
            if (r_state == ssg_pkg::ST_SH_WRJ && r_i == LW'(1)) begin
                r_pass_valid <= 1'b1;
                r_rd_pos     <= '0;
            end
            if (r_state == ssg_pkg::ST_OUT) begin
                if (r_last) begin
                    r_pass_valid <= 1'b0;
                    r_rd_pos     <= '0;
                end else begin
                    r_rd_pos <= r_pos + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ssg_pkg::ST_IDLE: begin
                r_i    <= '0;
                r_cell <= '0;
            end
            ssg_pkg::ST_FILL: begin
                if (r_i != eff_len - LW'(1)) begin
                    r_i <= r_i + LW'(1);
                end
                if (CLW'(r_cell) + CLW'(1) == eff_cells) begin
                    r_cell <= '0;
                end else begin
                    r_cell <= r_cell + DW'(1);
                end
            end
            ssg_pkg::ST_SH_RDJ: begin
                r_val_i <= mem_rdata;
                r_j     <= div_rem[AW-1:0];
            end
            ssg_pkg::ST_SH_WRJ: begin
                r_i <= r_i - LW'(1);
            end
            ssg_pkg::ST_READ: begin
                r_pos  <= pos_eff;
                r_last <= pos_last;
            end
            default: begin
                r_cell <= r_cell;
            end
        endcase
    end

    ssg_mem #(
        .DEPTH (MAX_SLOTS),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ssg_mod #(
        .LW (LW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (rng_next),
        .i_divisor  (r_i + LW'(1)),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign o_valid         = (r_state == ssg_pkg::ST_OUT);
    assign o_cell_index    = ssg_pkg::CELL_OUT_W'(mem_rdata);
    assign o_slot_position = ssg_pkg::POS_OUT_W'(r_pos);
    assign o_pass_end      = r_last;

endmodule

// ===== sv/ssg_mem.sv =====
// ----------------------------------------------------------------------------
// ssg_mem
// Schedule store: one write port, one read port, registered read data that
// holds its value between reads.
// ----------------------------------------------------------------------------
module ssg_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int DW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ssg_mod.sv =====
// ----------------------------------------------------------------------------
// ssg_mod
// Iterative remainder unit: 32-bit word modulo a narrow divisor, one
// restoring step per cycle, done pulse after the last step.
// ----------------------------------------------------------------------------
module ssg_mod #(
    parameter int LW = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [ssg_pkg::RNG_W-1:0] i_dividend,
    input  logic [LW-1:0]            i_divisor,
    output logic                     o_done,
    output logic [LW-1:0]            o_rem
);

    localparam int CNT_W = $clog2(ssg_pkg::RNG_W + 1);

    logic [ssg_pkg::RNG_W-1:0] r_dvd;
    logic [LW-1:0]             r_dsr;
    logic [LW-1:0]             r_rem;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_done;
    logic [LW:0]               n_shift;
    logic [LW-1:0]             n_rem;

    always_comb begin
        n_shift = {r_rem, r_dvd[ssg_pkg::RNG_W-1]};
        if (n_shift >= {1'b0, r_dsr}) begin
            n_rem = LW'(n_shift - {1'b0, r_dsr});
        end else begin
            n_rem = n_shift[LW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNT_W'(ssg_pkg::RNG_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_done <= (r_cnt == CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== test/shuffled_schedule_generator_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shuffled_schedule_generator_core_test
// Self-checking bench for the shuffled schedule generator. A directed plan
// covers clamped lengths and cell counts, restarts at and within a pass and
// register writes in mid-pass. A random part then walks a full-size pass and
// sweeps register settings and request streams with random gaps. Each beat is
// checked field by field against a local shuffle predictor or the plan row.
// ----------------------------------------------------------------------------
module shuffled_schedule_generator_core_test;

    localparam int          PERIOD_HALF  = 5;
    localparam int          RANDOM_ITEMS = 1425;
    localparam int          DRAIN_CYCLES = 8;
    localparam longint      CYCLE_LIMIT  = 4000000;
    localparam logic [ssg_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int          SLOT_CAP     = 512;
    localparam int          CELL_CAP     = 256;

    typedef struct packed {
        logic [ssg_pkg::CELL_OUT_W-1:0] cell_idx;
        logic [ssg_pkg::POS_OUT_W-1:0]  pos;
        logic                           last;
    } t_sched_entry;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_ASK,
        ROW_ASK_KNOWN
    } t_plan_op;

    typedef struct packed {
        t_plan_op                       op;
        logic [ssg_pkg::CFG_IDX_W-1:0]  idx;
        logic [ssg_pkg::CFG_DATA_W-1:0] data;
        logic                           restart;
        logic [ssg_pkg::CELL_OUT_W-1:0] cell_idx;
        logic [ssg_pkg::POS_OUT_W-1:0]  pos;
        logic                           last;
    } t_plan_row;

    localparam t_plan_row PLAN [37] = '{
        '{ROW_WRITE,     ssg_pkg::REG_CELLS,  32'd0,         1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_WRITE,     ssg_pkg::REG_LENGTH, 32'd0,         1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_ASK_KNOWN, ssg_pkg::REG_SEED,   32'd0,         1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_ASK_KNOWN, ssg_pkg::REG_SEED,   32'd0,         1'b0, 8'd0, 9'd1, 1'b1},
        '{ROW_ASK_KNOWN, ssg_pkg::REG_SEED,   32'd0,         1'b1, 8'd0, 9'd0, 1'b0},
        '{ROW_ASK_KNOWN, ssg_pkg::REG_SEED,   32'd0,         1'b1, 8'd0, 9'd0, 1'b0},
        '{ROW_ASK_KNOWN, ssg_pkg::REG_SEED,   32'd0,         1'b0, 8'd0, 9'd1, 1'b1},
        '{ROW_WRITE,     ssg_pkg::REG_LENGTH, 32'd1,         1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_ASK_KNOWN, ssg_pkg::REG_SEED,   32'd0,         1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_WRITE,     ssg_pkg::REG_LENGTH, 32'd3,         1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_WRITE,     ssg_pkg::REG_CELLS,  32'd1,         1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_ASK_KNOWN, ssg_pkg::REG_SEED,   32'd0,         1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_ASK_KNOWN, ssg_pkg::REG_SEED,   32'd0,         1'b0, 8'd0, 9'd1, 1'b0},
        '{ROW_ASK_KNOWN, ssg_pkg::REG_SEED,   32'd0,         1'b0, 8'd0, 9'd2, 1'b1},
        '{ROW_WRITE,     ssg_pkg::REG_SEED,   32'h0000_0000, 1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_WRITE,     ssg_pkg::REG_SEED,   32'hFFFF_FFFF, 1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_WRITE,     ssg_pkg::REG_LENGTH, 32'd1023,      1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_WRITE,     ssg_pkg::REG_CELLS,  32'd511,       1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_ASK,       ssg_pkg::REG_SEED,   32'd0,         1'b1, 8'd0, 9'd0, 1'b0},
        '{ROW_ASK,       ssg_pkg::REG_SEED,   32'd0,         1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_WRITE,     ssg_pkg::REG_LENGTH, 32'd512,       1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_WRITE,     ssg_pkg::REG_CELLS,  32'd256,       1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_ASK,       ssg_pkg::REG_SEED,   32'd0,         1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_WRITE,     ssg_pkg::REG_LENGTH, 32'd2,         1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_WRITE,     ssg_pkg::REG_CELLS,  32'd257,       1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_ASK,       ssg_pkg::REG_SEED,   32'd0,         1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_ASK,       ssg_pkg::REG_SEED,   32'd0,         1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_WRITE,     ssg_pkg::REG_SEED,   32'h9E37_79B9, 1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_WRITE,     ssg_pkg::REG_LENGTH, 32'd4,         1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_WRITE,     ssg_pkg::REG_CELLS,  32'd2,         1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_ASK,       ssg_pkg::REG_SEED,   32'd0,         1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_WRITE,     REG_SPARE,           32'hFFFF_FFFF, 1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_ASK,       ssg_pkg::REG_SEED,   32'd0,         1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_WRITE,     ssg_pkg::REG_CELLS,  32'd3,         1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_ASK,       ssg_pkg::REG_SEED,   32'd0,         1'b0, 8'd0, 9'd0, 1'b0},
        '{ROW_ASK,       ssg_pkg::REG_SEED,   32'd0,         1'b1, 8'd0, 9'd0, 1'b0},
        '{ROW_ASK,       ssg_pkg::REG_SEED,   32'd0,         1'b0, 8'd0, 9'd0, 1'b0}
    };

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            start;
    logic                            busy;
    logic                            i_restart;
    logic                            i_cfg_we;
    logic [ssg_pkg::CFG_IDX_W-1:0]   i_cfg_idx;
    logic [ssg_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                            o_valid;
    logic [ssg_pkg::CELL_OUT_W-1:0]  o_cell_index;
    logic [ssg_pkg::POS_OUT_W-1:0]   o_slot_position;
    logic                            o_pass_end;

    // shuffle predictor state
    logic [ssg_pkg::LEN_REG_W-1:0]   length_reg;
    logic [ssg_pkg::CELL_REG_W-1:0]  cells_reg;
    logic [ssg_pkg::RNG_W-1:0]       gen_word;
    logic [ssg_pkg::CELL_OUT_W-1:0]  slots [0:SLOT_CAP-1];
    int unsigned                     read_slot;
    bit                              pass_built;

    t_sched_entry           due_entries [$];
    t_sched_entry           head_entry;
    int unsigned            mismatch_count;
    int unsigned            beat_count;
    longint                 cycle_count;

    shuffled_schedule_generator_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_restart       (i_restart),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_cell_index    (o_cell_index),
        .o_slot_position (o_slot_position),
        .o_pass_end      (o_pass_end)
    );

    always begin
        #PERIOD_HALF i_clk = 1'b1;
        #PERIOD_HALF i_clk = 1'b0;
    end

    function automatic int unsigned slot_count();
        int unsigned n;
        n = length_reg;
        if (n < 2) begin
            n = 2;
        end
        if (n > SLOT_CAP) begin
            n = SLOT_CAP;
        end
        return n;
    endfunction

    function automatic int unsigned cell_count();
        int unsigned c;
        c = cells_reg;
        if (c < 1) begin
            c = 1;
        end
        if (c > CELL_CAP) begin
            c = CELL_CAP;
        end
        return c;
    endfunction

    function automatic logic [ssg_pkg::RNG_W-1:0] advance_gen(
        input logic [ssg_pkg::RNG_W-1:0] x);
        logic [ssg_pkg::RNG_W-1:0] y;
        y = x ^ {x[18:0], 13'd0};
        y = y ^ {17'd0, y[31:17]};
        y = y ^ {y[26:0], 5'd0};
        return y;
    endfunction

    task automatic build_schedule();
        int unsigned                     n;
        int unsigned                     c;
        int unsigned                     j;
        logic [ssg_pkg::CELL_OUT_W-1:0]  held;
        n = slot_count();
        c = cell_count();
        for (int unsigned i = 0; i < n; i++) begin
            slots[i] = ssg_pkg::CELL_OUT_W'(i % c);
        end
        for (int unsigned i = n - 1; i > 0; i--) begin
            gen_word = advance_gen(gen_word);
            j = gen_word % (i + 1);
            held = slots[i];
            slots[i] = slots[j];
            slots[j] = held;
        end
        read_slot = 0;
        pass_built = 1'b1;
    endtask

    task automatic predict_entry(input bit restart_req, output t_sched_entry e);
        int unsigned n;
        int unsigned p;
        if (restart_req || !pass_built) begin
            build_schedule();
        end
        n = slot_count();
        p = read_slot;
        if (p >= n) begin
            p = n - 1;
        end
        e.cell_idx = slots[p];
        e.pos      = ssg_pkg::POS_OUT_W'(p);
        e.last     = (p == n - 1);
        if (e.last) begin
            pass_built = 1'b0;
            read_slot = 0;
        end else begin
            read_slot = p + 1;
        end
    endtask

    task automatic apply_write(input logic [ssg_pkg::CFG_IDX_W-1:0] idx,
                               input logic [ssg_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            ssg_pkg::REG_SEED: begin
                gen_word = data | 32'd1;
                pass_built = 1'b0;
            end
            ssg_pkg::REG_LENGTH: begin
                length_reg = data[ssg_pkg::LEN_REG_W-1:0];
                pass_built = 1'b0;
            end
            ssg_pkg::REG_CELLS: begin
                cells_reg = data[ssg_pkg::CELL_REG_W-1:0];
                pass_built = 1'b0;
            end
            default: begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch on beat %0d, %s: got 0x%0h, want 0x%0h",
                 beat_count, what, got, want);
        mismatch_count++;
    endtask

    // hold a write until the block is idle and every beat has come back
    task automatic write_reg(input logic [ssg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ssg_pkg::CFG_DATA_W-1:0] data);
        start <= 1'b0;
        while (due_entries.size() != 0 || busy) begin
            i_cfg_we <= 1'b0;
            @(posedge i_clk);
        end
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        apply_write(idx, data);
    endtask

    task automatic issue(input bit restart_req, input int unsigned gap,
                         input bit typed, input t_sched_entry typed_entry);
        t_sched_entry e;
        i_cfg_we <= 1'b0;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_restart <= restart_req;
        do begin
            @(posedge i_clk);
        end while (busy);
        predict_entry(restart_req, e);
        due_entries.push_back(typed ? typed_entry : e);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (due_entries.size() == 0) begin
                report_mismatch("beat with nothing due", o_slot_position, 0);
            end else begin
                head_entry = due_entries.pop_front();
                if (o_cell_index !== head_entry.cell_idx) begin
                    report_mismatch("cell_index", o_cell_index, head_entry.cell_idx);
                end
                if (o_slot_position !== head_entry.pos) begin
                    report_mismatch("slot_position", o_slot_position, head_entry.pos);
                end
                if (o_pass_end !== head_entry.last) begin
                    report_mismatch("pass_end", o_pass_end, head_entry.last);
                end
            end
            beat_count++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        t_sched_entry                    typed_entry;
        int unsigned                     remaining;
        int unsigned                     items;
        int unsigned                     odds;
        int unsigned                     n_eff;
        int unsigned                     pick;
        bit                              quiet;
        bit                              first_phase;
        logic [ssg_pkg::CFG_DATA_W-1:0]  value;

        mismatch_count = 0;
        beat_count     = 0;
        cycle_count    = 0;
        length_reg     = ssg_pkg::RESET_LENGTH;
        cells_reg      = ssg_pkg::RESET_CELLS;
        gen_word       = ssg_pkg::RESET_SEED | 32'd1;
        read_slot      = 0;
        pass_built     = 1'b0;

        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_restart  <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= ssg_pkg::REG_SEED;
        i_cfg_data <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < $size(PLAN); k++) begin
            if (PLAN[k].op == ROW_WRITE) begin
                write_reg(PLAN[k].idx, PLAN[k].data);
            end else begin
                typed_entry = '{cell_idx: PLAN[k].cell_idx, pos: PLAN[k].pos,
                                last: PLAN[k].last};
                issue(PLAN[k].restart, $urandom_range(0, 19),
                      PLAN[k].op == ROW_ASK_KNOWN, typed_entry);
            end
        end

        remaining   = RANDOM_ITEMS;
        first_phase = 1'b1;
        while (remaining > 0) begin
            if (first_phase) begin
                // walk one full-size pass to reach the top slot and cell
                write_reg(ssg_pkg::REG_SEED, $urandom);
                write_reg(ssg_pkg::REG_LENGTH, 32'd512);
                write_reg(ssg_pkg::REG_CELLS, 32'd256);
            end else begin
                if ($urandom_range(0, 1) == 0) begin
                    pick = $urandom_range(0, 7);
                    value = (pick == 0) ? 32'h0000_0000 :
                            (pick == 1) ? 32'hFFFF_FFFF : $urandom;
                    write_reg(ssg_pkg::REG_SEED, value);
                end
                if ($urandom_range(0, 3) != 0) begin
                    pick = $urandom_range(0, 15);
                    case (pick)
                        0:       value = $urandom_range(0, 1);
                        1:       value = $urandom_range(513, 1023);
                        2:       value = $urandom_range(100, 512);
                        default: value = $urandom_range(2, 40);
                    endcase
                    write_reg(ssg_pkg::REG_LENGTH, value);
                end
                if ($urandom_range(0, 3) != 0) begin
                    pick = $urandom_range(0, 15);
                    case (pick)
                        0:       value = 0;
                        1:       value = $urandom_range(257, 511);
                        2:       value = 256;
                        default: value = $urandom_range(1, 48);
                    endcase
                    write_reg(ssg_pkg::REG_CELLS, value);
                end
                if ($urandom_range(0, 7) == 0) begin
                    write_reg(REG_SPARE, $urandom);
                end
            end

            n_eff = slot_count();
            if (first_phase) begin
                items = SLOT_CAP;
                odds  = 0;
            end else if (n_eff > 64) begin
                items = $urandom_range(1, 30);
                odds  = 32;
            end else begin
                items = $urandom_range(1, 3 * n_eff + 2);
                odds  = 16;
            end
            if (items > remaining) begin
                items = remaining;
            end
            quiet = ($urandom_range(0, 3) == 0);
            repeat (items) begin
                issue((odds != 0) && ($urandom_range(1, odds) == 1),
                      quiet ? 0 : $urandom_range(0, 19), 1'b0, typed_entry);
            end
            remaining   -= items;
            first_phase  = 1'b0;
        end

        start    <= 1'b0;
        i_cfg_we <= 1'b0;
        while (due_entries.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ssg_pkg.sv
sv/ssg_mem.sv
sv/ssg_mod.sv
sv/shuffled_schedule_generator_core.sv
test/shuffled_schedule_generator_core_test.sv
